// ===== rtl/pqrr_pkg.sv =====
// Shared types and constants for the per-user queue round-robin scheduler.
package pqrr_pkg;

   localparam int MAX_USERS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam logic [4:0]  LIMIT_RESET = 5'd16;
   localparam logic [19:0] BYTES_MAX   = 20'hFFFFF;

   localparam logic [1:0] CMD_ADD  = 2'd0;
   localparam logic [1:0] CMD_ENQ  = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;

   localparam logic [2:0] STS_OK         = 3'd0;
   localparam logic [2:0] STS_UNKNOWN    = 3'd1;
   localparam logic [2:0] STS_TABLE_FULL = 3'd2;
   localparam logic [2:0] STS_QUEUE_FULL = 3'd3;
   localparam logic [2:0] STS_IDLE       = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] user_id;
      logic [15:0] beam_id;
      logic [15:0] pkt_handle;
      logic [15:0] pkt_bytes;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] out_user;
      logic [15:0] out_beam;
      logic [15:0] out_handle;
      logic [15:0] out_bytes;
      logic [31:0] queue_delay;
      logic [19:0] queue_bytes;
   } rsp_type;

   function automatic logic [19:0] sat_bytes(input logic [31:0] b);
      logic [19:0] r;
      if (b > 32'(BYTES_MAX)) begin
         r = BYTES_MAX;
      end else begin
         r = b[19:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/pqrr_ram.sv =====
// Generic single-port-write, registered-read RAM.
module pqrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/per_user_queue_round_robin_scheduler.sv =====
// Top level: user table search, per-user descriptor FIFOs, round-robin tick.
//
//  channel | ports                          | beat taken when
//  --------+--------------------------------+-------------------------
//  request | start, busy, req_data          | start && !busy
//  result  | rsp_valid, rsp_data            | rsp_valid (one cycle)
//  config  | csr_wr_en, csr_wr_data         | csr_wr_en
//
// Each user-table probe reads (S_RD), then compares (S_CHK), on the user RAM port.
// Add/enqueue probe users from index 0; tick probes from the cursor, plus S_DESC
// for the descriptor RAM read when a packet is found. Empty table or command three:
// busy is never raised. The strobe rises in the same cycle that busy drops.
// Reset clears state and counters; RAM contents need no clearing. No output stall.
module per_user_queue_round_robin_scheduler
   import pqrr_pkg::*;
#(
   parameter int MAX_USERS   = MAX_USERS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data
);

   localparam int UA = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int CW = $clog2(MAX_USERS + 1);
   localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = FW + 1;
   localparam int TW = 16 + FW;
   localparam int DDEPTH = MAX_USERS * QUEUE_DEPTH;
   localparam int DA = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;

   typedef struct packed {
      logic [15:0]   id;
      logic [15:0]   beam;
      logic [HW-1:0] head;
      logic [FW-1:0] fill;
      logic [TW-1:0] total;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RD   = 4'b0010,
      S_CHK  = 4'b0100,
      S_DESC = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic [UA-1:0] idx_ff, idx_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] count_ff, count_in;
   logic [UA-1:0] cursor_ff, cursor_in;
   logic [4:0]    limit_ff, limit_in;
   req_type       req_ff, req_in;
   entry_type     ent_ff, ent_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          ent_we, ent_re;
   logic [UA-1:0] ent_waddr, ent_raddr;
   entry_type     ent_wdata, ent_rd;
   logic          desc_we, desc_re;
   logic [DA-1:0] desc_waddr, desc_raddr;
   logic [63:0]   desc_wdata, desc_rd;

   req_type       cur;
   logic [CW-1:0] idx_nx, k_nx;
   logic [UA-1:0] idx_wrap;
   logic [SW-1:0] slot_sum;
   logic [HW-1:0] slot, head_nx;
   logic [HW:0]   head_inc;
   logic [31:0]   lim;
   logic [15:0]   d_bytes;
   logic [TW-1:0] tot_new;
   logic          do_miss, do_idle;

   pqrr_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_USERS)) u_user_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (ent_re),
      .rd_addr (ent_raddr),
      .rd_data (ent_rd)
   );

   pqrr_ram #(.WIDTH(64), .DEPTH(DDEPTH)) u_desc_ram (
      .clock   (clock),
      .wr_en   (desc_we),
      .wr_addr (desc_waddr),
      .wr_data (desc_wdata),
      .rd_en   (desc_re),
      .rd_addr (desc_raddr),
      .rd_data (desc_rd)
   );

   assign cur      = (state_ff == S_IDLE) ? req_data : req_ff;
   assign idx_nx   = CW'(idx_ff) + CW'(1);
   assign k_nx     = k_ff + CW'(1);
   assign idx_wrap = (idx_nx == count_ff) ? '0 : UA'(idx_nx);
   assign lim      = (32'(limit_ff) < 32'(QUEUE_DEPTH)) ? 32'(limit_ff) : 32'(QUEUE_DEPTH);
   assign slot_sum = SW'(ent_rd.head) + SW'(ent_rd.fill);
   assign slot     = (slot_sum >= SW'(QUEUE_DEPTH)) ? HW'(slot_sum - SW'(QUEUE_DEPTH))
                                                    : HW'(slot_sum);
   assign head_inc = (HW + 1)'(ent_ff.head) + (HW + 1)'(1);
   assign head_nx  = (head_inc == (HW + 1)'(QUEUE_DEPTH)) ? '0 : HW'(head_inc);
   assign d_bytes  = desc_rd[31:16];
   assign tot_new  = ent_rd.total + TW'(req_ff.pkt_bytes);
   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      req_in       = req_ff;
      ent_in       = ent_ff;
      rsp_in       = '0;
      rsp_valid_in = 1'b0;
      ent_we       = 1'b0;
      ent_waddr    = idx_ff;
      ent_wdata    = ent_ff;
      ent_re       = 1'b0;
      ent_raddr    = idx_ff;
      desc_we      = 1'b0;
      desc_waddr   = DA'(idx_ff) * DA'(QUEUE_DEPTH) + DA'(slot);
      desc_wdata   = {req_ff.now, req_ff.pkt_bytes, req_ff.pkt_handle};
      desc_re      = 1'b0;
      desc_raddr   = DA'(idx_ff) * DA'(QUEUE_DEPTH) + DA'(ent_rd.head);
      do_miss      = 1'b0;
      do_idle      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               k_in   = '0;
               priority case (req_data.cmd)
                  CMD_ADD, CMD_ENQ: begin
                     if (count_ff == '0) begin
                        do_miss = 1'b1;
                     end else begin
                        idx_in   = '0;
                        state_in = S_RD;
                     end
                  end
                  CMD_TICK: begin
                     if (count_ff == '0) begin
                        do_idle = 1'b1;
                     end else begin
                        idx_in   = cursor_ff;
                        state_in = S_RD;
                     end
                  end
                  default: do_idle = 1'b1;
               endcase
            end
         end
         S_RD: begin
            ent_re   = 1'b1;
            state_in = S_CHK;
         end
         S_CHK: begin
            ent_in = ent_rd;
            if (req_ff.cmd == CMD_TICK) begin
               if (ent_rd.fill != '0) begin
                  desc_re  = 1'b1;
                  state_in = S_DESC;
               end else if (k_nx == count_ff) begin
                  do_idle = 1'b1;
               end else begin
                  k_in     = k_nx;
                  idx_in   = idx_wrap;
                  state_in = S_RD;
               end
            end else if (ent_rd.id == req_ff.user_id) begin
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
               rsp_in.out_user  = req_ff.user_id;
               if (req_ff.cmd == CMD_ADD) begin
                  ent_we             = 1'b1;
                  ent_wdata          = ent_rd;
                  ent_wdata.beam     = req_ff.beam_id;
                  rsp_in.status      = STS_OK;
                  rsp_in.out_beam    = req_ff.beam_id;
                  rsp_in.queue_bytes = sat_bytes(32'(ent_rd.total));
               end else if (32'(ent_rd.fill) >= lim) begin
                  rsp_in.status      = STS_QUEUE_FULL;
                  rsp_in.out_beam    = ent_rd.beam;
                  rsp_in.queue_bytes = sat_bytes(32'(ent_rd.total));
               end else begin
                  desc_we            = 1'b1;
                  ent_we             = 1'b1;
                  ent_wdata          = ent_rd;
                  ent_wdata.fill     = ent_rd.fill + FW'(1);
                  ent_wdata.total    = tot_new;
                  rsp_in.status      = STS_OK;
                  rsp_in.out_beam    = ent_rd.beam;
                  rsp_in.queue_bytes = sat_bytes(32'(tot_new));
               end
            end else if (idx_nx == count_ff) begin
               do_miss = 1'b1;
            end else begin
               idx_in   = UA'(idx_nx);
               state_in = S_RD;
            end
         end
         S_DESC: begin
            ent_we             = 1'b1;
            ent_wdata          = ent_ff;
            ent_wdata.head     = head_nx;
            ent_wdata.fill     = ent_ff.fill - FW'(1);
            ent_wdata.total    = ent_ff.total - TW'(d_bytes);
            cursor_in          = idx_wrap;
            rsp_valid_in       = 1'b1;
            rsp_in.status      = STS_OK;
            rsp_in.out_user    = ent_ff.id;
            rsp_in.out_beam    = ent_ff.beam;
            rsp_in.out_handle  = desc_rd[15:0];
            rsp_in.out_bytes   = d_bytes;
            rsp_in.queue_delay = req_ff.now - desc_rd[63:32];
            rsp_in.queue_bytes = sat_bytes(32'(ent_ff.total - TW'(d_bytes)));
            state_in           = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (do_idle) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = '0;
         rsp_in.status = STS_IDLE;
         state_in      = S_IDLE;
      end
      if (do_miss) begin
         rsp_valid_in    = 1'b1;
         rsp_in          = '0;
         rsp_in.out_user = cur.user_id;
         state_in        = S_IDLE;
         if (cur.cmd == CMD_ADD) begin
            if (count_ff >= CW'(MAX_USERS)) begin
               rsp_in.status = STS_TABLE_FULL;
            end else begin
               ent_we          = 1'b1;
               ent_waddr       = UA'(count_ff);
               ent_wdata       = '0;
               ent_wdata.id    = cur.user_id;
               ent_wdata.beam  = cur.beam_id;
               count_in        = count_ff + CW'(1);
               rsp_in.status   = STS_OK;
               rsp_in.out_beam = cur.beam_id;
            end
         end else begin
            rsp_in.status = STS_UNKNOWN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      k_ff   <= k_in;
      req_ff <= req_in;
      ent_ff <= ent_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
